[design/pad_spi_flash_mirror_defines.svh]
// assertion macros for the flash mirror block
`ifndef PAD_SPI_FLASH_MIRROR_DEFINES_SVH
`define PAD_SPI_FLASH_MIRROR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PSFM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define PSFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/psfm_pkg.sv]
// shared types, window constants and stick block table for the flash mirror
package psfm_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_LOAD  = 2'd2
    } req_t;

    // address window classes
    typedef enum logic [1:0] {
        REGION_NONE  = 2'd0,
        REGION_FACT  = 2'd1,
        REGION_STICK = 2'd2,
        REGION_USER  = 2'd3
    } region_t;

    // factory windows all sit in one 256-byte page
    localparam logic [23:0] FACT_PAGE = 24'h000060;
    localparam logic [23:0] USER_PAGE = 24'h000080;

    localparam logic [7:0] IMU_LO   = 8'h20;
    localparam logic [7:0] IMU_LEN  = 8'd24;
    localparam logic [7:0] STICK_LO  = 8'h3D;
    localparam logic [7:0] STICK_LEN = 8'd18;
    localparam logic [7:0] COLOR_LO  = 8'h50;
    localparam logic [7:0] COLOR_LEN = 8'd13;
    localparam logic [7:0] PAR1_LO  = 8'h80;
    localparam logic [7:0] PAR1_LEN = 8'd24;
    localparam logic [7:0] PAR2_LO  = 8'h98;
    localparam logic [7:0] PAR2_LEN = 8'd18;

    // factory store layout follows address order
    localparam int          FACT_DEPTH     = 97;
    localparam logic [6:0]  FACT_LAST      = 7'd96;
    localparam logic [6:0]  FACT_OFS_IMU   = 7'd0;
    localparam logic [6:0]  FACT_OFS_COLOR = 7'd42;
    localparam logic [6:0]  FACT_OFS_PAR1  = 7'd55;
    localparam logic [6:0]  FACT_OFS_PAR2  = 7'd79;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // stick calibration centre and range, 12 bits each
    localparam logic [11:0] STICK_C = 12'd2048;
    localparam logic [11:0] STICK_R = 12'd1800;

    // decoded view of one request
    typedef struct packed {
        region_t    region;
        logic [6:0] fact_idx;
        logic [4:0] stick_idx;
        logic       user_hit;
        logic       load_ok;
    } psfm_dec_t;

    // packing of two 12-bit values into three bytes
    function automatic logic [7:0] pack_lo(input logic [11:0] a);
        return a[7:0];
    endfunction

    function automatic logic [7:0] pack_mid(input logic [11:0] a, input logic [11:0] b);
        return {b[3:0], a[11:8]};
    endfunction

    function automatic logic [7:0] pack_hi(input logic [11:0] b);
        return b[11:4];
    endfunction

    // fixed stick block: left stick (R,R,C,C,R,R) then right stick (C,C,R,R,R,R)
    function automatic logic [7:0] stick_byte(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:    val = pack_lo(STICK_R);
            5'd1:    val = pack_mid(STICK_R, STICK_R);
            5'd2:    val = pack_hi(STICK_R);
            5'd3:    val = pack_lo(STICK_C);
            5'd4:    val = pack_mid(STICK_C, STICK_C);
            5'd5:    val = pack_hi(STICK_C);
            5'd6:    val = pack_lo(STICK_R);
            5'd7:    val = pack_mid(STICK_R, STICK_R);
            5'd8:    val = pack_hi(STICK_R);
            5'd9:    val = pack_lo(STICK_C);
            5'd10:   val = pack_mid(STICK_C, STICK_C);
            5'd11:   val = pack_hi(STICK_C);
            5'd12:   val = pack_lo(STICK_R);
            5'd13:   val = pack_mid(STICK_R, STICK_R);
            5'd14:   val = pack_hi(STICK_R);
            5'd15:   val = pack_lo(STICK_R);
            5'd16:   val = pack_mid(STICK_R, STICK_R);
            5'd17:   val = pack_hi(STICK_R);
            default: val = ERASED_BYTE;
        endcase
        return val;
    endfunction

endpackage

[design/psfm_decode.sv]
// address decode of one request into window class and store indexes
module psfm_decode
    import psfm_pkg::*;
#(
    parameter int SLOT_COUNT     = 4,
    parameter int USER_CAL_BYTES = 256,
    parameter int UIDX_W         = 10
) (
    input  logic [1:0]        slot,
    input  logic [31:0]       address,
    output psfm_dec_t         dec,
    output logic              slot_ok,
    output logic [UIDX_W-1:0] user_idx
);

    logic [7:0]  lo;
    logic        fact_page;
    logic [7:0]  imu_ofs;
    logic [7:0]  stick_ofs;
    logic [7:0]  color_ofs;
    logic [7:0]  par1_ofs;
    logic [7:0]  par2_ofs;
    logic [31:0] user_sum;

    assign lo        = address[7:0];
    assign fact_page = (address[31:8] == FACT_PAGE);
    assign imu_ofs   = lo - IMU_LO;
    assign stick_ofs = lo - STICK_LO;
    assign color_ofs = lo - COLOR_LO;
    assign par1_ofs  = lo - PAR1_LO;
    assign par2_ofs  = lo - PAR2_LO;

    // slot range and flat index into the user store
    assign slot_ok  = ({30'd0, slot} < 32'(SLOT_COUNT));
    assign user_sum = ({30'd0, slot} * 32'(USER_CAL_BYTES)) + {24'd0, lo};
    assign user_idx = user_sum[UIDX_W-1:0];

    // window selection, windows do not overlap
    always_comb
    begin
        dec.region    = REGION_NONE;
        dec.fact_idx  = FACT_OFS_IMU;
        dec.stick_idx = stick_ofs[4:0];
        dec.user_hit  = (address[31:8] == USER_PAGE) && ({24'd0, lo} < 32'(USER_CAL_BYTES));
        dec.load_ok   = (address[31:7] == 25'd0) && (address[6:0] <= FACT_LAST);
        if (fact_page && (lo >= IMU_LO) && (imu_ofs < IMU_LEN))
        begin
            dec.region   = REGION_FACT;
            dec.fact_idx = FACT_OFS_IMU + imu_ofs[6:0];
        end
        else if (fact_page && (lo >= STICK_LO) && (stick_ofs < STICK_LEN))
        begin
            dec.region = REGION_STICK;
        end
        else if (fact_page && (lo >= COLOR_LO) && (color_ofs < COLOR_LEN))
        begin
            dec.region   = REGION_FACT;
            dec.fact_idx = FACT_OFS_COLOR + color_ofs[6:0];
        end
        else if (fact_page && (lo >= PAR1_LO) && (par1_ofs < PAR1_LEN))
        begin
            dec.region   = REGION_FACT;
            dec.fact_idx = FACT_OFS_PAR1 + par1_ofs[6:0];
        end
        else if (fact_page && (lo >= PAR2_LO) && (par2_ofs < PAR2_LEN))
        begin
            dec.region   = REGION_FACT;
            dec.fact_idx = FACT_OFS_PAR2 + par2_ofs[6:0];
        end
        else if (dec.user_hit)
        begin
            dec.region = REGION_USER;
        end
    end

endmodule

[design/psfm_fact_mem.sv]
// factory table store, one write port and one registered read port
module psfm_fact_mem
    import psfm_pkg::*;
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [6:0] wr_idx,
    input  logic [7:0] wr_data,
    input  logic       rd_en,
    input  logic [6:0] rd_idx,
    output logic [7:0] rd_data
);

    logic [7:0] mem [FACT_DEPTH];
    logic [7:0] rd_data_reg;

    // store writes from load transactions
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/psfm_user_mem.sv]
// user calibration store, read-first single port with clearing pass after reset
module psfm_user_mem
    import psfm_pkg::*;
#(
    parameter int SLOT_COUNT     = 4,
    parameter int USER_CAL_BYTES = 256,
    parameter int UIDX_W         = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              we,
    input  logic [UIDX_W-1:0] idx,
    input  logic [7:0]        wr_data,
    output logic [7:0]        rd_data,
    output logic              clearing
);

    localparam int DEPTH = SLOT_COUNT * USER_CAL_BYTES;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [UIDX_W-1:0] clr_cnt_reg;
    logic [UIDX_W-1:0] clr_cnt_next;
    logic              port_we;
    logic [UIDX_W-1:0] port_idx;
    logic [7:0]        port_data;

    // clearing sweep, one entry per cycle
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == UIDX_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // write port shared by the sweep and write transactions
    assign port_we   = clearing_reg || we;
    assign port_idx  = clearing_reg ? clr_cnt_reg : idx;
    assign port_data = clearing_reg ? ERASED_BYTE : wr_data;

    // read returns the old byte when the same entry is written
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[idx];
        end
        if (port_we)
        begin
            mem[port_idx] <= port_data;
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

[design/pad_spi_flash_mirror.sv]
// top level of the emulated controller SPI flash mirror
//
// One byte transaction per request. A request is taken on a rising edge with
// start high and busy low: read (req_type 0), write (1) into the per-slot user
// calibration window at 0x8000, or load (2) of a factory table byte, where
// address is the table index 0..96. Reads decode the address into the IMU,
// stick, colour and parameter windows and the user window; other addresses
// read 0xFF. The stick window always reads a fixed packed block.
// Each request gives one result: done is high for exactly one cycle with
// read_data, byte_changed and burst_end valid, after the input and result
// registers. While busy is low a new request can be taken every cycle; each
// request touches the single-port user store at most once (read and write on
// the same edge) and the factory store at most once. The receiver cannot
// stall; results are never held. After reset busy stays high while the
// SLOT_COUNT * USER_CAL_BYTES entries of the user store (1024 at the defaults)
// are swept to 0xFF; factory bytes must be loaded before they are read.
`include "pad_spi_flash_mirror_defines.svh"

module pad_spi_flash_mirror
    import psfm_pkg::*;
#(
    parameter int SLOT_COUNT     = 4,
    parameter int USER_CAL_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [1:0]  slot,
    input  logic [31:0] address,
    input  logic [7:0]  write_data,
    input  logic        last_byte,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        byte_changed,
    output logic        burst_end
);

    localparam int UIDX_W = $clog2(SLOT_COUNT * USER_CAL_BYTES);

    psfm_dec_t         dec;
    logic              slot_ok;
    logic [UIDX_W-1:0] user_idx;
    logic              accept;
    logic              user_ok;
    logic [7:0]        fact_rdata;
    logic [7:0]        user_rdata;
    logic              clearing;

    logic       s1_valid_reg;
    logic [1:0] s1_req_reg;
    region_t    s1_region_reg;
    logic [4:0] s1_stick_idx_reg;
    logic       s1_user_ok_reg;
    logic [7:0] s1_wdata_reg;
    logic       s1_last_reg;

    logic       done_reg;
    logic [7:0] read_data_reg;
    logic       byte_changed_reg;
    logic       burst_end_reg;
    logic [7:0] read_data_next;
    logic       byte_changed_next;

    assign busy    = clearing;
    assign accept  = start && !clearing;
    assign user_ok = dec.user_hit && slot_ok;

    // address decode
    psfm_decode #(
        .SLOT_COUNT     (SLOT_COUNT),
        .USER_CAL_BYTES (USER_CAL_BYTES),
        .UIDX_W         (UIDX_W)
    ) u_decode (
        .slot     (slot),
        .address  (address),
        .dec      (dec),
        .slot_ok  (slot_ok),
        .user_idx (user_idx)
    );

    // factory table store
    psfm_fact_mem u_fact_mem (
        .clk     (clk),
        .wr_en   (accept && (req_type == REQ_LOAD) && dec.load_ok),
        .wr_idx  (address[6:0]),
        .wr_data (write_data),
        .rd_en   (accept && (req_type == REQ_READ) && (dec.region == REGION_FACT)),
        .rd_idx  (dec.fact_idx),
        .rd_data (fact_rdata)
    );

    // user calibration store
    psfm_user_mem #(
        .SLOT_COUNT     (SLOT_COUNT),
        .USER_CAL_BYTES (USER_CAL_BYTES),
        .UIDX_W         (UIDX_W)
    ) u_user_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept && user_ok),
        .we       (accept && user_ok && (req_type == REQ_WRITE)),
        .idx      (user_idx),
        .wr_data  (write_data),
        .rd_data  (user_rdata),
        .clearing (clearing)
    );

    // input register, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // input register, payload part
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg       <= req_type;
            s1_region_reg    <= dec.region;
            s1_stick_idx_reg <= dec.stick_idx;
            s1_user_ok_reg   <= user_ok;
            s1_wdata_reg     <= write_data;
            s1_last_reg      <= last_byte;
        end
    end

    // result formation
    always_comb
    begin
        read_data_next    = 8'h00;
        byte_changed_next = 1'b0;
        case (s1_req_reg)
            REQ_READ:
            begin
                case (s1_region_reg)
                    REGION_FACT:  read_data_next = fact_rdata;
                    REGION_STICK: read_data_next = stick_byte(s1_stick_idx_reg);
                    REGION_USER:  read_data_next = s1_user_ok_reg ? user_rdata : ERASED_BYTE;
                    default:      read_data_next = ERASED_BYTE;
                endcase
            end
            REQ_WRITE:
            begin
                byte_changed_next = s1_user_ok_reg && (user_rdata != s1_wdata_reg);
            end
            default:
            begin
                read_data_next = 8'h00;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            read_data_reg    <= 8'h00;
            byte_changed_reg <= 1'b0;
            burst_end_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                read_data_reg    <= read_data_next;
                byte_changed_reg <= byte_changed_next;
                burst_end_reg    <= s1_last_reg;
            end
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign byte_changed = byte_changed_reg;
    assign burst_end    = burst_end_reg;

    // checks
    `PSFM_ASSERT_NEXT(a_accept_gives_done, start && !busy, ##1 done, "taken transaction gave no result")
    `PSFM_ASSERT_IMPLY(a_done_has_cause, done, $past(start && !busy, 2), "result without a transaction")
    `PSFM_ASSERT_IMPLY(a_changed_is_write, done && byte_changed, read_data == 8'h00, "changed flag on a read")

endmodule
